### rtl/core/psv_pkg.sv
// Shared constants and codes for the plucked string voice.
// No dependencies; compiled before every other file of the block.
package psv_pkg;

   // Delay line geometry
   localparam int MAX_LINE   = 4096;
   localparam int LINE_AW    = $clog2(MAX_LINE);
   localparam int LEN_W      = LINE_AW + 1;
   localparam int MEM_AW     = LINE_AW + 1;      // bank bit plus line index
   localparam int MEM_DEPTH  = 2 * MAX_LINE;
   localparam int SAMPLE_W   = 16;
   localparam int MAX_FADE   = 256;
   localparam int FADE_CNT_W = 9;

   // Q1.16 unity and related constants
   localparam logic [16:0] Q16_ONE    = 17'h10000;
   localparam logic [16:0] BRIGHT_LO  = 17'd19661;   // 0.3
   localparam logic [16:0] BRIGHT_SPN = 17'd45875;   // 0.7
   localparam logic [16:0] FB_GAIN    = 17'd19661;   // 0.3
   localparam logic [16:0] VEL_MIN    = 17'd655;     // 0.01

   // Register reset values
   localparam logic [12:0] LEN_RST    = 13'd100;
   localparam logic [15:0] WEIGHT_RST = 16'd32768;
   localparam logic [16:0] DECAY_RST  = 17'h10000;
   localparam logic [16:0] FSTEP_RST  = 17'd0;

   // Opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_FILL  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_LENGTH = 2'd0;
   localparam logic [1:0] REG_WEIGHT = 2'd1;
   localparam logic [1:0] REG_DECAY  = 2'd2;
   localparam logic [1:0] REG_FSTEP  = 2'd3;

   localparam int PADDR_W = 4;

endpackage

### rtl/core/psv_if.sv
// Valid/ready channel interfaces for the voice's request and response sides.
// Depends on nothing; widths follow the item fields.
interface psv_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic               pluck_first;
   logic signed [15:0] noise_value;
   logic [16:0]        strike_velocity;

   modport source (output valid, opcode, pluck_first, noise_value, strike_velocity,
                   input ready);
   modport sink   (input valid, opcode, pluck_first, noise_value, strike_velocity,
                   output ready);
endinterface

interface psv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] audio_out;
   logic               sounding;
   logic               fading;

   modport source (output valid, audio_out, sounding, fading, input ready);
   modport sink   (input valid, audio_out, sounding, fading, output ready);
endinterface

### rtl/core/psv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module psv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### rtl/core/plucked_string_voice.sv
// Karplus-Strong plucked string voice. A tick reads the current and next line
// entries, interpolates and decays them and writes back, then mixes in the
// snapshot bank while a crossfade runs; a fill element scales noise into one entry.
// The shared 18x18 multiplier and the single read port of the line RAM set the steps.
// Synchronous active-high reset clears the control state and the configuration
// registers; the working registers and the line RAM are not cleared.
module plucked_string_voice (
   input  logic                         clock,
   input  logic                         reset,
   psv_req_if.sink                      req_ch,
   psv_rsp_if.source                    rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [psv_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import psv_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8,
      S_F0, S_F1, S_F2, S_F3, S_F4, S_DONE
   } state_type;

   function automatic logic signed [21:0] rnd_q16(input logic signed [37:0] x);
      logic signed [37:0] y;
      y = (x + 38'sd32768) >>> 16;
      return y[21:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
      if (x > 18'sd32767) return 16'sh7FFF;
      if (x < -18'sd32768) return 16'sh8000;
      return x[15:0];
   endfunction

   state_type state_ff;

   // configuration registers
   logic [12:0] line_length_ff;
   logic [15:0] interp_weight_ff;
   logic [16:0] decay_gain_ff;
   logic [16:0] fade_step_ff;

   // voice state
   logic [LINE_AW-1:0]    ring_pos_ff;
   logic [LEN_W-1:0]      fill_pos_ff;
   logic                  filling_ff;
   logic signed [15:0]    fill_prev_ff;
   logic [16:0]           held_vel_ff;
   logic                  voice_on_ff;
   logic                  fade_on_ff;
   logic [FADE_CNT_W-1:0] fade_count_ff;
   logic [16:0]           fade_amount_ff;
   logic                  bank_ff;

   // per-item working registers
   logic signed [15:0] noise_ff;
   logic               quiet_ff;
   logic [LINE_AW-1:0] r_ff, n_ff;
   logic signed [15:0] cur_ff, nxt_ff, scur_ff, snxt_ff;
   logic signed [35:0] acc_ff;
   logic signed [17:0] live_ff, po_ff, s_ff, res_ff;
   logic [16:0]        b_ff, k_ff;

   // response register
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_audio_ff;
   logic               rsp_sounding_ff, rsp_fading_ff;

   // datapath nets
   logic [LEN_W-1:0]       len_c;
   logic [LINE_AW-1:0]     rpos_c, npos_c;
   logic [LEN_W-1:0]       rnext_c;
   logic [16:0]            wi_c;
   logic signed [17:0]     mul_a, mul_b;
   logic signed [35:0]     mul_p;
   logic signed [21:0]     rsum_c, rprod_c;
   logic signed [15:0]     out_sat_c;
   logic [17:0]            fa_sum_c;
   logic [FADE_CNT_W-1:0]  fcount_dec_c;
   logic [LEN_W-1:0]       fill_next_c;
   logic [LEN_W-3:0]       quarter_c;
   logic [16:0]            vel_c;
   logic                   cfg_wr, slot_free, req_xfer;

   // RAM ports
   logic              ram_we;
   logic [MEM_AW-1:0] ram_waddr, ram_raddr;
   logic [15:0]       ram_wdata, ram_rdata;

   psv_ram #(.WIDTH(SAMPLE_W), .DEPTH(MEM_DEPTH)) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // effective line length and ring positions
   always_comb begin
      if (line_length_ff < 13'd2) len_c = LEN_W'(2);
      else if (line_length_ff > 13'(MAX_LINE)) len_c = LEN_W'(MAX_LINE);
      else len_c = LEN_W'(line_length_ff);
      rpos_c  = ({1'b0, ring_pos_ff} >= len_c) ? '0 : ring_pos_ff;
      rnext_c = {1'b0, rpos_c} + LEN_W'(1);
      npos_c  = (rnext_c == len_c) ? '0 : rnext_c[LINE_AW-1:0];
      quarter_c = len_c[LEN_W-1:2];
   end

   assign wi_c = Q16_ONE - {1'b0, interp_weight_ff};

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_T2: begin mul_a = 18'(cur_ff);  mul_b = $signed({1'b0, wi_c}); end
         S_T3: begin mul_a = 18'(nxt_ff);  mul_b = $signed({2'b0, interp_weight_ff}); end
         S_T4: begin mul_a = live_ff;      mul_b = $signed({1'b0, decay_gain_ff}); end
         S_T5: begin mul_a = 18'(scur_ff); mul_b = $signed({1'b0, wi_c}); end
         S_T6: begin mul_a = 18'(snxt_ff); mul_b = $signed({2'b0, interp_weight_ff}); end
         S_T7: begin
            mul_a = po_ff;
            mul_b = $signed({1'b0, Q16_ONE - fade_amount_ff});
         end
         S_T8: begin mul_a = live_ff;      mul_b = $signed({1'b0, fade_amount_ff}); end
         S_F0: begin mul_a = $signed({1'b0, BRIGHT_SPN}); mul_b = $signed({1'b0, held_vel_ff}); end
         S_F1: begin mul_a = $signed({1'b0, Q16_ONE - b_ff}); mul_b = $signed({1'b0, FB_GAIN}); end
         S_F2: begin mul_a = 18'(noise_ff); mul_b = $signed({1'b0, b_ff}); end
         S_F3: begin mul_a = 18'(fill_prev_ff); mul_b = $signed({1'b0, k_ff}); end
         S_F4: begin mul_a = s_ff;         mul_b = $signed({1'b0, held_vel_ff}); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign rsum_c  = rnd_q16({{2{acc_ff[35]}}, acc_ff} + {{2{mul_p[35]}}, mul_p});
   assign rprod_c = rnd_q16({{2{mul_p[35]}}, mul_p});
   assign out_sat_c = sat16(res_ff);
   assign fa_sum_c  = {1'b0, fade_amount_ff} + {1'b0, fade_step_ff};
   assign fcount_dec_c = (fade_count_ff != '0) ? fade_count_ff - 1'b1 : fade_count_ff;
   assign fill_next_c  = fill_pos_ff + 1'b1;
   assign vel_c = (req_ch.strike_velocity < VEL_MIN) ? VEL_MIN :
                  (req_ch.strike_velocity > Q16_ONE) ? Q16_ONE : req_ch.strike_velocity;

   // RAM read address per step; live bank is bank_ff, snapshot the other
   always_comb begin
      case (state_ff)
         S_T0:    ram_raddr = {bank_ff, rpos_c};
         S_T1:    ram_raddr = {bank_ff, n_ff};
         S_T2:    ram_raddr = {~bank_ff, r_ff};
         S_T3:    ram_raddr = {~bank_ff, n_ff};
         default: ram_raddr = {bank_ff, r_ff};
      endcase
   end

   // write-back of a tick or a fill element
   assign ram_we    = (state_ff == S_T4) || (state_ff == S_F4);
   assign ram_waddr = (state_ff == S_F4) ? {bank_ff, fill_pos_ff[LINE_AW-1:0]}
                                         : {bank_ff, r_ff};
   assign ram_wdata = sat16(rprod_c[17:0]);

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer = req_ch.valid && (state_ff == S_IDLE);

   // sequencer and voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         ring_pos_ff    <= '0;
         fill_pos_ff    <= '0;
         filling_ff     <= 1'b0;
         fill_prev_ff   <= '0;
         held_vel_ff    <= '0;
         voice_on_ff    <= 1'b0;
         fade_on_ff     <= 1'b0;
         fade_count_ff  <= '0;
         fade_amount_ff <= '0;
         bank_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         quiet_ff       <= 1'b0;
      end else begin
         // a new result loaded in S_DONE takes the place of the one leaving
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  noise_ff <= req_ch.noise_value;
                  case (req_ch.opcode)
                     OP_TICK: begin
                        if (voice_on_ff && !filling_ff) begin
                           quiet_ff <= 1'b0;
                           state_ff <= S_T0;
                        end else begin
                           quiet_ff <= 1'b1;
                           res_ff   <= '0;
                           state_ff <= S_DONE;
                        end
                     end
                     OP_FILL: begin
                        if (req_ch.pluck_first) begin
                           held_vel_ff <= vel_c;
                           if (voice_on_ff) begin
                              // old line becomes the snapshot bank
                              bank_ff        <= ~bank_ff;
                              fade_count_ff  <= (quarter_c < (LEN_W-2)'(MAX_FADE)) ?
                                                FADE_CNT_W'(quarter_c) : FADE_CNT_W'(MAX_FADE);
                              fade_on_ff     <= (quarter_c != '0);
                           end else begin
                              fade_count_ff  <= '0;
                              fade_on_ff     <= 1'b0;
                           end
                           fade_amount_ff <= '0;
                           voice_on_ff    <= 1'b0;
                           filling_ff     <= 1'b1;
                           fill_pos_ff    <= '0;
                           fill_prev_ff   <= '0;
                           state_ff       <= S_F0;
                        end else if (filling_ff) begin
                           state_ff <= S_F0;
                        end
                     end
                     OP_CLEAR: begin
                        ring_pos_ff    <= '0;
                        fill_pos_ff    <= '0;
                        filling_ff     <= 1'b0;
                        fill_prev_ff   <= '0;
                        voice_on_ff    <= 1'b0;
                        fade_on_ff     <= 1'b0;
                        fade_count_ff  <= '0;
                        fade_amount_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            // tick: read current, next, then both snapshot entries
            S_T0: begin
               r_ff     <= rpos_c;
               n_ff     <= npos_c;
               state_ff <= S_T1;
            end
            S_T1: begin
               cur_ff   <= ram_rdata;
               state_ff <= S_T2;
            end
            S_T2: begin
               nxt_ff   <= ram_rdata;
               acc_ff   <= mul_p;
               state_ff <= S_T3;
            end
            S_T3: begin
               scur_ff  <= ram_rdata;
               live_ff  <= rsum_c[17:0];
               state_ff <= S_T4;
            end
            S_T4: begin
               snxt_ff  <= ram_rdata;
               res_ff   <= live_ff;
               state_ff <= fade_on_ff ? S_T5 : S_DONE;
            end
            S_T5: begin
               acc_ff   <= mul_p;
               state_ff <= S_T6;
            end
            S_T6: begin
               po_ff    <= rsum_c[17:0];
               state_ff <= S_T7;
            end
            S_T7: begin
               acc_ff   <= mul_p;
               state_ff <= S_T8;
            end
            S_T8: begin
               res_ff   <= rsum_c[17:0];
               state_ff <= S_DONE;
            end
            // fill: brightness, feedback factor, filter, velocity scale
            S_F0: begin
               b_ff     <= BRIGHT_LO + {1'b0, mul_p[31:16]};
               state_ff <= S_F1;
            end
            S_F1: begin
               k_ff     <= {1'b0, mul_p[31:16]};
               state_ff <= S_F2;
            end
            S_F2: begin
               acc_ff   <= mul_p;
               state_ff <= S_F3;
            end
            S_F3: begin
               s_ff     <= rsum_c[17:0];
               state_ff <= S_F4;
            end
            S_F4: begin
               fill_prev_ff <= ram_wdata;
               fill_pos_ff  <= fill_next_c;
               if (fill_next_c >= len_c) begin
                  filling_ff  <= 1'b0;
                  voice_on_ff <= 1'b1;
                  ring_pos_ff <= '0;
               end
               state_ff <= S_IDLE;
            end
            // result transfer and end-of-tick update
            S_DONE: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_audio_ff <= out_sat_c;
                  if (quiet_ff) begin
                     rsp_sounding_ff <= voice_on_ff;
                     rsp_fading_ff   <= fade_on_ff;
                  end else begin
                     ring_pos_ff <= n_ff;
                     if (fade_on_ff) begin
                        fade_amount_ff <= (fa_sum_c > {1'b0, Q16_ONE}) ? Q16_ONE
                                                                      : fa_sum_c[16:0];
                        fade_count_ff  <= fcount_dec_c;
                        if (fcount_dec_c == '0) fade_on_ff <= 1'b0;
                        rsp_fading_ff <= (fcount_dec_c != '0);
                     end else begin
                        rsp_fading_ff <= 1'b0;
                     end
                     if (out_sat_c >= -16'sd3 && out_sat_c <= 16'sd3) begin
                        voice_on_ff     <= 1'b0;
                        rsp_sounding_ff <= 1'b0;
                     end else begin
                        rsp_sounding_ff <= voice_on_ff;
                     end
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.audio_out = rsp_audio_ff;
   assign rsp_ch.sounding  = rsp_sounding_ff;
   assign rsp_ch.fading    = rsp_fading_ff;

   // configuration registers
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff   <= LEN_RST;
         interp_weight_ff <= WEIGHT_RST;
         decay_gain_ff    <= DECAY_RST;
         fade_step_ff     <= FSTEP_RST;
      end else if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_LENGTH: line_length_ff   <= csr_pwdata[12:0];
            REG_WEIGHT: interp_weight_ff <= csr_pwdata[15:0];
            REG_DECAY:  decay_gain_ff <= (csr_pwdata[16:0] > Q16_ONE) ? Q16_ONE
                                                                      : csr_pwdata[16:0];
            REG_FSTEP:  fade_step_ff  <= (csr_pwdata[16:0] > Q16_ONE) ? Q16_ONE
                                                                      : csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_LENGTH: csr_prdata = {19'd0, line_length_ff};
         REG_WEIGHT: csr_prdata = {16'd0, interp_weight_ff};
         REG_DECAY:  csr_prdata = {15'd0, decay_gain_ff};
         REG_FSTEP:  csr_prdata = {15'd0, fade_step_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // checks
   a_ram_we_step: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_T4 || state_ff == S_F4))
      else $error("line RAM written outside a write-back step");
   a_fill_silent: assert property (@(posedge clock) disable iff (reset)
      filling_ff |-> !voice_on_ff)
      else $error("voice on while a fill is in progress");
   a_fade_count: assert property (@(posedge clock) disable iff (reset)
      fade_on_ff |-> (fade_count_ff != '0))
      else $error("crossfade active with no ticks left");
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for plucked_string_voice: plucks, ticks, clears and
// crossfades, checked against an in-bench string model. Needs psv_pkg and psv_if.
module tb_top;
   import psv_pkg::*;

   typedef struct {
      logic [1:0]         op;
      logic               first;
      logic signed [15:0] noise;
      logic [16:0]        vel;
   } string_cmd_t;

   typedef struct {
      logic signed [15:0] audio;
      logic               sounding;
      logic               fading;
   } voice_sample_t;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int LONG_HOLD   = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [PADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   psv_req_if req_ch ();
   psv_rsp_if rsp_ch ();

   plucked_string_voice i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   string_cmd_t   cmd_queue[$];
   voice_sample_t sample_queue[$];
   string_cmd_t   cmd_on_bus;
   int            gap_left = 0;
   int            stall_left = 0;
   bit            hold_request = 0;
   bit            hold_taken = 0;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            random_items = 0;

   // String model: registers and voice state
   int  len_reg, weight_reg, decay_reg, fstep_reg;
   int  str_mem[MAX_LINE];
   int  snap_mem[MAX_LINE];
   int  ring_pos, fill_pos, fill_prev, held_vel, fade_count, fade_amt;
   bit  filling, voice_on, fade_on;

   function automatic longint round_q16(longint x);
      return (x + 32768) >>> 16;
   endfunction

   function automatic longint sat_sample(longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
   endfunction

   function automatic int line_len();
      if (len_reg < 2) return 2;
      if (len_reg > MAX_LINE) return MAX_LINE;
      return len_reg;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic clear_string();
      for (int i = 0; i < MAX_LINE; i++) begin
         str_mem[i] = 0;
         snap_mem[i] = 0;
      end
      ring_pos = 0;
      fill_pos = 0;
      filling = 0;
      fill_prev = 0;
      voice_on = 0;
      fade_on = 0;
      fade_count = 0;
      fade_amt = 0;
   endtask

   task automatic fill_string(string_cmd_t c);
      int     len;
      longint v, b, k, s, w, q;
      len = line_len();
      if (c.first) begin
         v = c.vel;
         if (v < VEL_MIN) v = VEL_MIN;
         if (v > Q16_ONE) v = Q16_ONE;
         held_vel = v;
         if (voice_on) begin
            for (int i = 0; i < MAX_LINE; i++) snap_mem[i] = str_mem[i];
            q = len / 4;
            fade_count = (q < MAX_FADE) ? q : MAX_FADE;
            fade_amt = 0;
            fade_on = fade_count > 0;
         end else begin
            fade_on = 0;
            fade_count = 0;
            fade_amt = 0;
         end
         voice_on = 0;
         filling = 1;
         fill_pos = 0;
         fill_prev = 0;
      end
      if (!filling) return;
      v = held_vel;
      b = BRIGHT_LO + ((BRIGHT_SPN * v) >> 16);
      k = ((65536 - b) * FB_GAIN) >> 16;
      s = round_q16(longint'(c.noise) * b + longint'(fill_prev) * k);
      w = sat_sample(round_q16(s * v));
      if (fill_pos < MAX_LINE) str_mem[fill_pos] = w;
      fill_prev = w;
      fill_pos++;
      if (fill_pos >= len) begin
         filling = 0;
         voice_on = 1;
         ring_pos = 0;
      end
   endtask

   // Advance the voice by one sample and queue the sample it should emit
   task automatic tick_string();
      voice_sample_t e;
      int     len, r, n;
      longint w, y, po, t, fa;
      y = 0;
      if (voice_on && !filling) begin
         len = line_len();
         w = weight_reg;
         if (ring_pos >= len) ring_pos = 0;
         r = ring_pos;
         n = (r + 1 == len) ? 0 : r + 1;
         y = round_q16(longint'(str_mem[r]) * (65536 - w) + longint'(str_mem[n]) * w);
         str_mem[r] = sat_sample(round_q16(y * decay_reg));
         ring_pos = n;
         if (fade_on) begin
            po = round_q16(longint'(snap_mem[r]) * (65536 - w)
                           + longint'(snap_mem[n]) * w);
            t = (fade_amt > 65536) ? 65536 : fade_amt;
            fa = fade_amt + fstep_reg;
            y = round_q16(po * (65536 - t) + y * t);
            fade_amt = (fa > 65536) ? 65536 : fa;
            if (fade_count > 0) fade_count--;
            if (fade_count == 0) fade_on = 0;
         end
         y = sat_sample(y);
         if (y >= -3 && y <= 3) voice_on = 0;
      end
      e.audio = y[15:0];
      e.sounding = voice_on;
      e.fading = fade_on;
      sample_queue.push_back(e);
   endtask

   task automatic string_step(string_cmd_t c);
      case (c.op)
         OP_TICK:  tick_string();
         OP_FILL:  fill_string(c);
         OP_CLEAR: clear_string();
         default: ;
      endcase
   endtask

   // Clock and cycle limit
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Request driver: predicts each transfer as it is accepted
   always @(posedge clock) begin
      string_cmd_t nx;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) string_step(cmd_on_bus);
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               nx = cmd_queue.pop_front();
               cmd_on_bus = nx;
               req_ch.valid <= 1'b1;
               req_ch.opcode <= nx.op;
               req_ch.pluck_first <= nx.first;
               req_ch.noise_value <= nx.noise;
               req_ch.strike_velocity <= nx.vel;
               gap_left = pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random and long stalls
   always @(posedge clock) begin
      voice_sample_t e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (sample_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected transfer: audio %0d sounding %0d fading %0d",
                           rsp_ch.audio_out, rsp_ch.sounding, rsp_ch.fading);
            end else begin
               e = sample_queue.pop_front();
               if (rsp_ch.audio_out !== e.audio || rsp_ch.sounding !== e.sounding ||
                   rsp_ch.fading !== e.fading) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp audio %0d snd %0d fad %0d, got %0d %0d %0d",
                              e.audio, e.sounding, e.fading,
                              rsp_ch.audio_out, rsp_ch.sounding, rsp_ch.fading);
               end
            end
         end
         if (hold_request && !hold_taken) begin
            hold_taken = 1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Stimulus helpers
   task automatic push_cmd(logic [1:0] op, logic first, logic signed [15:0] noise,
                           logic [16:0] vel);
      string_cmd_t c;
      c.op = op;
      c.first = first;
      c.noise = noise;
      c.vel = vel;
      cmd_queue.push_back(c);
      random_items++;
   endtask

   function automatic logic [15:0] rand_noise();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'h8000;
      if (r == 1) return 16'h7fff;
      return $urandom_range(0, 65535);
   endfunction

   task automatic pluck(int n, logic [16:0] vel);
      for (int i = 0; i < n; i++)
         push_cmd(OP_FILL, i == 0, rand_noise(), (i == 0) ? vel : $urandom_range(0, 131071));
   endtask

   task automatic ticks(int n);
      for (int i = 0; i < n; i++) push_cmd(OP_TICK, 1'b0, rand_noise(), 17'd0);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_queue.size() != 0 || req_ch.valid || sample_queue.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= PADDR_W'(idx) << 2;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_LENGTH: len_reg = val[12:0];
         REG_WEIGHT: weight_reg = val[15:0];
         REG_DECAY:  decay_reg = (val[16:0] > Q16_ONE) ? Q16_ONE : val[16:0];
         default:    fstep_reg = (val[16:0] > Q16_ONE) ? Q16_ONE : val[16:0];
      endcase
   endtask

   // One long line early on; the rest stay short to keep the item count near target
   function automatic logic [31:0] pick_length(int phase);
      int r;
      if (phase == 1) return 32'd1100;
      r = $urandom_range(0, 19);
      if (r == 0) return $urandom_range(0, 1);
      if (r < 3) return $urandom_range(4, 5);
      return $urandom_range(2, 40);
   endfunction

   function automatic logic [31:0] pick_decay();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 131071;
      if (r == 2) return Q16_ONE;
      return $urandom_range(58000, 65535);
   endfunction

   function automatic logic [31:0] pick_fstep();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 0;
      if (r == 1) return 131071;
      if (r == 2) return Q16_ONE;
      return $urandom_range(100, 30000);
   endfunction

   function automatic logic [31:0] pick_weight();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 16384;
      if (r == 1) return 49152;
      if (r == 2) return $urandom_range(0, 65535);
      return $urandom_range(16384, 49152);
   endfunction

   // Main sequence
   initial begin
      int len, phase;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_TICK;
      req_ch.pluck_first = 1'b0;
      req_ch.noise_value = '0;
      req_ch.strike_velocity = '0;
      rsp_ch.ready = 1'b0;
      len_reg = LEN_RST;
      weight_reg = WEIGHT_RST;
      decay_reg = DECAY_RST;
      fstep_reg = FSTEP_RST;
      held_vel = 0;
      clear_string();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: silent tick, ignored items, plucks with crossfade, aborted pluck
      csr_write(REG_LENGTH, 4);
      csr_write(REG_FSTEP, 20000);
      ticks(1);
      push_cmd(OP_FILL, 1'b0, 16'h1234, 17'd0);
      push_cmd(2'd3, 1'b1, 16'h7fff, 17'h1ffff);
      push_cmd(OP_FILL, 1'b1, 16'h7fff, 17'd0);
      push_cmd(OP_FILL, 1'b0, 16'h8000, 17'd0);
      push_cmd(OP_FILL, 1'b0, 16'h7fff, 17'd0);
      push_cmd(OP_FILL, 1'b0, 16'h8000, 17'd0);
      ticks(3);
      push_cmd(OP_FILL, 1'b1, 16'h8000, 17'h1ffff);
      push_cmd(OP_FILL, 1'b0, 16'h8000, 17'h1ffff);
      push_cmd(OP_FILL, 1'b0, 16'h7fff, 17'h10000);
      push_cmd(OP_FILL, 1'b0, 16'h8000, 17'h0);
      ticks(3);
      pluck(2, 17'h10000);
      ticks(1);
      pluck(4, 17'd40000);
      ticks(2);
      push_cmd(OP_CLEAR, 1'b0, 16'h0, 17'h0);
      ticks(1);
      random_items = 0;

      // Random phases, each starting from a cleared voice with fresh registers
      phase = 0;
      while (random_items < 1500) begin
         push_cmd(OP_CLEAR, 1'b0, rand_noise(), 17'd0);
         wait_drained();
         csr_write(REG_LENGTH, pick_length(phase));
         csr_write(REG_WEIGHT, pick_weight());
         csr_write(REG_DECAY, pick_decay());
         csr_write(REG_FSTEP, pick_fstep());
         len = line_len();
         if (phase == 0) hold_request = 1;
         repeat ((len > 100) ? 1 : $urandom_range(3, 8)) begin
            case ($urandom_range(0, 9))
               0: begin
                  pluck($urandom_range(1, len), $urandom_range(0, 131071));
                  ticks($urandom_range(0, 2));
               end
               1: push_cmd($urandom_range(0, 1) ? 2'd3 : OP_FILL, 1'b0, rand_noise(),
                           $urandom_range(0, 131071));
               2: push_cmd(OP_CLEAR, 1'b0, rand_noise(), 17'd0);
               default: ;
            endcase
            pluck(len, $urandom_range(0, 131071));
            ticks($urandom_range(0, (len > 100) ? 300 : 2 * len + 10));
         end
         phase++;
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### plucked_string_voice.f
rtl/core/psv_pkg.sv
rtl/core/psv_if.sv
rtl/core/psv_ram.sv
rtl/core/plucked_string_voice.sv
tb/tb_top.sv
